[src/assert_macros.svh]
// Assertion macros shared by the RTL of the frame checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge out of reset
`define SRFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge out of reset
`define SRFC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SRFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRFC_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[src/srfc_pkg.sv]
// Types, codes, constants and CRC function of the sensor frame checker
package srfc_pkg;

  // Input item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_WAIT  = 2'd1;
  localparam logic [1:0] MODE_BYTE  = 2'd2;

  // Frame phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_CRC  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_CRC     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMI_LIMIT = 1'd1;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [3:0] TEMP_LIMIT_RST = 4'd10;
  localparam logic [3:0] HUMI_LIMIT_RST = 4'd5;

  // CRC-8, polynomial 0x31
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Code mask drops the two status bits
  localparam logic [15:0] CODE_MASK = 16'hFFFC;

  // Conversion: floor(code * scale / 65536) - offset
  localparam logic [14:0] TEMP_SCALE  = 15'd17572;
  localparam logic [14:0] HUMI_SCALE  = 15'd12500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4685;
  localparam logic [15:0] HUMI_OFFSET = 16'd600;

  localparam logic [4:0] WAIT_MAX = 5'd31;
  localparam logic [7:0] ERR_MAX  = 8'd255;

  typedef logic signed [14:0] centi_t;

  // Feed one byte into the running CRC, MSB first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[src/srfc_in_if.sv]
// Input item channel of the sensor frame checker
interface srfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic       quantity;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output quantity, output rx_byte, input ready);
  modport sink   (input valid, input mode, input quantity, input rx_byte, output ready);
endinterface

[src/srfc_out_if.sv]
// Result item channel of the sensor frame checker
interface srfc_out_if
  import srfc_pkg::*;
;
  logic        valid;
  logic        ready;
  logic        quantity_out;
  logic [1:0]  status;
  centi_t      value_centi;
  logic [15:0] raw_code;
  logic [7:0]  error_count;

  modport source (output valid, output quantity_out, output status, output value_centi,
                  output raw_code, output error_count, input ready);
  modport sink   (input valid, input quantity_out, input status, input value_centi,
                  input raw_code, input error_count, output ready);
endinterface

[src/srfc_cfg_if.sv]
// Configuration write channel of the sensor frame checker
interface srfc_cfg_if
  import srfc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/sensor_reading_frame_check.sv]
// Sensor frame checker: wait timeout, CRC-8 check and reading conversion
//
// Takes one item per clock cycle while waiting results are taken. Each item
// passes an input register and then a result register. The result register
// is loaded from the input register when it is empty or its result is taken,
// and the result is offered straight from it. Start, wait tick and the first
// two bytes give no result. The CRC byte and a wait tick past the limit give
// one. in_ch.ready falls only when the input register is full and a waiting
// result is not taken. The frame state, CRC and error counter are updated by
// a single pass of logic between the two registers. Its longest path is one
// 16 x 15 bit multiply and a subtract for the reading conversion.
// Configuration writes are always accepted and take effect at once.
`include "assert_macros.svh"

module sensor_reading_frame_check
  import srfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  srfc_in_if.sink       in_ch,
  srfc_out_if.source    out_ch,
  srfc_cfg_if.sink      cfg_ch
);

  // Configuration registers
  logic [3:0] temp_limit_r;
  logic [3:0] humi_limit_r;

  // Input register
  logic       s1_vld_r;
  logic [1:0] s1_mode_r;
  logic       s1_qty_r;
  logic [7:0] s1_byte_r;

  // Frame state
  logic [1:0] phase_r,  phase_nxt;
  logic       qty_r,    qty_nxt;
  logic [4:0] wait_r,   wait_nxt;
  logic [7:0] high_r,   high_nxt;
  logic [7:0] low_r,    low_nxt;
  logic [7:0] crc_r,    crc_nxt;
  logic [7:0] err_r,    err_nxt;

  // Result register
  logic        out_vld_r;
  logic        out_qty_r,   out_qty_nxt;
  logic [1:0]  out_st_r,    out_st_nxt;
  centi_t      out_val_r,   out_val_nxt;
  logic [15:0] out_raw_r,   out_raw_nxt;
  logic [7:0]  out_err_r,   out_err_nxt;
  logic        res_vld;

  logic        adv;
  logic        step;
  logic [7:0]  crc_fed;
  logic [7:0]  err_bumped;
  logic [3:0]  limit;
  logic [15:0] code;
  logic [14:0] scale;
  logic [30:0] prod;
  logic [15:0] offset;
  logic [15:0] conv;

  // Handshakes
  assign adv          = !out_vld_r || out_ch.ready;
  assign step         = adv && s1_vld_r;
  assign in_ch.ready  = !s1_vld_r || adv;
  assign cfg_ch.ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_limit_r <= TEMP_LIMIT_RST;
      humi_limit_r <= HUMI_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_TEMP_LIMIT: temp_limit_r <= cfg_ch.data;
        CFG_HUMI_LIMIT: humi_limit_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_mode_r <= in_ch.mode;
      s1_qty_r  <= in_ch.quantity;
      s1_byte_r <= in_ch.rx_byte;
    end
  end

  // Shared helpers: CRC step, saturating error bump, limit select
  assign crc_fed    = crc8_feed(crc_r, s1_byte_r);
  assign err_bumped = (err_r == ERR_MAX) ? err_r : err_r + 8'd1;
  assign limit      = qty_r ? humi_limit_r : temp_limit_r;

  // Reading conversion, one multiplier shared by both quantities
  assign code   = {high_r, low_r} & CODE_MASK;
  assign scale  = qty_r ? HUMI_SCALE : TEMP_SCALE;
  assign offset = qty_r ? HUMI_OFFSET : TEMP_OFFSET;
  assign prod   = 31'(code) * 31'(scale);
  assign conv   = {1'b0, prod[30:16]} - offset;

  // Frame processing for the item in the input register
  always_comb begin
    phase_nxt   = phase_r;
    qty_nxt     = qty_r;
    wait_nxt    = wait_r;
    high_nxt    = high_r;
    low_nxt     = low_r;
    crc_nxt     = crc_r;
    err_nxt     = err_r;
    res_vld     = 1'b0;
    out_qty_nxt = qty_r;
    out_st_nxt  = ST_OK;
    out_val_nxt = '0;
    out_raw_nxt = '0;
    out_err_nxt = err_r;
    if (step) begin
      case (s1_mode_r)
        MODE_START: begin
          phase_nxt = PH_HIGH;
          qty_nxt   = s1_qty_r;
          wait_nxt  = '0;
          crc_nxt   = '0;
        end
        MODE_WAIT: begin
          if (phase_r == PH_HIGH) begin
            wait_nxt = (wait_r == WAIT_MAX) ? wait_r : wait_r + 5'd1;
            if (wait_nxt > {1'b0, limit}) begin
              err_nxt     = err_bumped;
              phase_nxt   = PH_IDLE;
              res_vld     = 1'b1;
              out_st_nxt  = ST_TIMEOUT;
              out_err_nxt = err_bumped;
            end
          end
        end
        MODE_BYTE: begin
          case (phase_r)
            PH_HIGH: begin
              high_nxt  = s1_byte_r;
              crc_nxt   = crc_fed;
              phase_nxt = PH_LOW;
            end
            PH_LOW: begin
              low_nxt   = s1_byte_r;
              crc_nxt   = crc_fed;
              phase_nxt = PH_CRC;
            end
            PH_CRC: begin
              phase_nxt   = PH_IDLE;
              res_vld     = 1'b1;
              out_raw_nxt = code;
              if (s1_byte_r != crc_r) begin
                err_nxt     = err_bumped;
                out_st_nxt  = ST_CRC;
                out_err_nxt = err_bumped;
              end else begin
                out_val_nxt = conv[14:0];
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      qty_r   <= 1'b0;
      wait_r  <= '0;
      high_r  <= '0;
      low_r   <= '0;
      crc_r   <= '0;
      err_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      qty_r   <= qty_nxt;
      wait_r  <= wait_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
      crc_r   <= crc_nxt;
      err_r   <= err_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_qty_r <= out_qty_nxt;
      out_st_r  <= out_st_nxt;
      out_val_r <= out_val_nxt;
      out_raw_r <= out_raw_nxt;
      out_err_r <= out_err_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.quantity_out = out_qty_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.value_centi  = out_val_r;
  assign out_ch.raw_code     = out_raw_r;
  assign out_ch.error_count  = out_err_r;

  // Checks
  `SRFC_ASSERT(a_frame_ends_idle, clk, rst_n, (step && res_vld) |=> (phase_r == PH_IDLE), "result without return to idle")
  `SRFC_ASSERT(a_err_monotonic, clk, rst_n, $past(rst_n) |-> (err_r >= $past(err_r)), "error count fell")
  `SRFC_ASSERT(a_ready_when_empty, clk, rst_n, !out_vld_r |-> in_ch.ready, "input stalled with empty result register")
  `SRFC_ASSERT(a_timeout_zero, clk, rst_n, (out_vld_r && out_st_r == ST_TIMEOUT) |-> (out_val_r == '0 && out_raw_r == '0), "timeout result carries data")
  `SRFC_NEVER(a_raw_low_bits, clk, rst_n, out_vld_r && (out_raw_r[1:0] != 2'b00), "raw code status bits not cleared")

endmodule

[tb/sensor_reading_frame_check_tb.sv]
// Self-checking testbench for the sensor frame checker: directed table, then random frames
module sensor_reading_frame_check_tb
  import srfc_pkg::*;
;

  // Mode three has no meaning in the block and must be ignored
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [3:0] TEMP_LIMIT_AT_RESET = 4'd10;
  localparam logic [3:0] HUMI_LIMIT_AT_RESET = 4'd5;
  localparam int unsigned TEMP_GAIN = 17572;
  localparam int unsigned HUMI_GAIN = 12500;
  localparam int TEMP_BASE = 4685;
  localparam int HUMI_BASE = 600;

  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic        quantity;
    logic [1:0]  status;
    centi_t      value;
    logic [15:0] raw;
    logic [7:0]  errs;
  } reading_t;

  // One stimulus item; a pinned row carries its expected reading typed in
  typedef struct packed {
    logic [1:0] mode;
    logic       qty;
    logic [7:0] rx;
    logic       auto_crc;
    logic       pinned;
    reading_t   want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  srfc_in_if  in_ch();
  srfc_out_if out_ch();
  srfc_cfg_if cfg_ch();

  sensor_reading_frame_check dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Frame predictor state and its copy of the limits
  logic [1:0] fr_phase;
  logic       fr_qty;
  logic [4:0] fr_waits;
  logic [7:0] fr_hi;
  logic [7:0] fr_lo;
  logic [7:0] fr_crc;
  logic [7:0] err_total;
  logic [3:0] lim_temp;
  logic [3:0] lim_humi;

  reading_t expected_readings[$];
  dir_row_t dir_rows[$];

  int       mismatch_count = 0;
  int       result_no = 0;
  int       frame_items = 0;
  int       quiet_cycles = 0;
  int       send_idle_pct = 30;
  int       recv_idle_pct = 61;
  logic     hold_req = 1'b0;
  logic     hold_done = 1'b0;
  int       hold_left = 0;
  logic     row_pinned;
  reading_t row_want;

  reading_t mon_reading;
  reading_t mon_want;
  logic     mon_hit;
  logic     mon_acted;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // CRC-8, polynomial 0x31, bit-serial, MSB first
  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[7] ^ b[i];
      acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return acc;
  endfunction

  function automatic void count_error();
    if (err_total != 8'hFF) err_total++;
  endfunction

  // Advance the frame state by one item; returns 1 when a reading is due
  function automatic logic predict_reading(input logic [1:0] m, input logic q,
                                           input logic [7:0] b, output reading_t r,
                                           output logic acted);
    logic [15:0] code;
    logic [3:0]  lim;
    logic [31:0] prod;
    int          v;
    r = '0;
    acted = 1'b0;
    case (m)
      MODE_START: begin
        acted    = 1'b1;
        fr_phase = PH_HIGH;
        fr_qty   = q;
        fr_waits = 5'd0;
        fr_crc   = 8'h00;
      end
      MODE_WAIT: begin
        if (fr_phase == PH_HIGH) begin
          acted = 1'b1;
          if (fr_waits != 5'd31) fr_waits++;
          lim = fr_qty ? lim_humi : lim_temp;
          // exactly at the limit still proceeds; one past it times out
          if (fr_waits > {1'b0, lim}) begin
            count_error();
            fr_phase   = PH_IDLE;
            r.quantity = fr_qty;
            r.status   = ST_TIMEOUT;
            r.errs     = err_total;
            return 1'b1;
          end
        end
      end
      MODE_BYTE: begin
        case (fr_phase)
          PH_HIGH: begin
            acted    = 1'b1;
            fr_hi    = b;
            fr_crc   = crc8_step(fr_crc, b);
            fr_phase = PH_LOW;
          end
          PH_LOW: begin
            acted    = 1'b1;
            fr_lo    = b;
            fr_crc   = crc8_step(fr_crc, b);
            fr_phase = PH_CRC;
          end
          PH_CRC: begin
            acted      = 1'b1;
            fr_phase   = PH_IDLE;
            code       = {fr_hi, fr_lo[7:2], 2'b00};
            r.quantity = fr_qty;
            r.raw      = code;
            if (b != fr_crc) begin
              count_error();
              r.status = ST_CRC;
            end else begin
              prod = fr_qty ? 32'(code) * HUMI_GAIN : 32'(code) * TEMP_GAIN;
              v = int'(prod >> 16) - (fr_qty ? HUMI_BASE : TEMP_BASE);
              r.status = ST_OK;
              r.value  = v[14:0];
            end
            r.errs = err_total;
            return 1'b1;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Prediction on accepted items and writes, checking on accepted readings
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TEMP_LIMIT: lim_temp = cfg_ch.data;
          CFG_HUMI_LIMIT: lim_humi = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        mon_hit = predict_reading(in_ch.mode, in_ch.quantity, in_ch.rx_byte,
                                  mon_reading, mon_acted);
        if (row_pinned) expected_readings.push_back(row_want);
        else if (mon_hit) expected_readings.push_back(mon_reading);
        if (mon_acted) frame_items++;
      end
      if (out_ch.valid && out_ch.ready) begin
        result_no++;
        if (expected_readings.size() == 0) begin
          note_mismatch($sformatf("reading %0d arrived with none pending (status %0d)",
                                  result_no, out_ch.status));
        end else begin
          mon_want = expected_readings.pop_front();
          if (out_ch.quantity_out !== mon_want.quantity)
            note_mismatch($sformatf("reading %0d quantity %0d, expected %0d", result_no,
                                    out_ch.quantity_out, mon_want.quantity));
          if (out_ch.status !== mon_want.status)
            note_mismatch($sformatf("reading %0d status %0d, expected %0d", result_no,
                                    out_ch.status, mon_want.status));
          if (out_ch.value_centi !== mon_want.value)
            note_mismatch($sformatf("reading %0d value %0d, expected %0d", result_no,
                                    $signed(out_ch.value_centi), $signed(mon_want.value)));
          if (out_ch.raw_code !== mon_want.raw)
            note_mismatch($sformatf("reading %0d raw code %h, expected %h", result_no,
                                    out_ch.raw_code, mon_want.raw));
          if (out_ch.error_count !== mon_want.errs)
            note_mismatch($sformatf("reading %0d error count %0d, expected %0d", result_no,
                                    out_ch.error_count, mon_want.errs));
        end
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no item moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Reading sink: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done    = 1'b1;
        hold_left    = HOLD_CYCLES;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic dir_row_t row(input logic [1:0] m, input logic q, input logic [7:0] b);
    dir_row_t d;
    d      = '0;
    d.mode = m;
    d.qty  = q;
    d.rx   = b;
    return d;
  endfunction

  function automatic dir_row_t checked_row(input logic [1:0] m, input logic q,
                                           input logic [7:0] b, input logic auto_crc,
                                           input logic wq, input logic [1:0] st,
                                           input int val, input logic [15:0] raw,
                                           input logic [7:0] errs);
    dir_row_t d;
    d                = row(m, q, b);
    d.auto_crc       = auto_crc;
    d.pinned         = 1'b1;
    d.want.quantity  = wq;
    d.want.status    = st;
    d.want.value     = val[14:0];
    d.want.raw       = raw;
    d.want.errs      = errs;
    return d;
  endfunction

  // Offer one item, with random idle cycles first; returns after acceptance
  task automatic offer(input logic [1:0] m, input logic q, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid    = 1'b1;
    in_ch.mode     = m;
    in_ch.quantity = q;
    in_ch.rx_byte  = b;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // One frame: start, wait ticks, high, low and CRC byte, possibly cut short
  task automatic send_frame(input int timeout_pct, input int badcrc_pct);
    dir_row_t   steps[$];
    dir_row_t   s;
    logic       q;
    logic [3:0] lim;
    logic       late;
    int         nw;
    int         cut;
    logic [7:0] spoil;
    q     = 1'($urandom_range(0, 1));
    lim   = q ? lim_humi : lim_temp;
    late  = ($urandom_range(0, 99) < timeout_pct);
    nw    = late ? int'(lim) + 1 + int'($urandom_range(0, 1)) : int'($urandom_range(0, lim));
    cut   = ($urandom_range(0, 99) < 8) ? int'($urandom_range(1, 4)) : 1000;
    spoil = ($urandom_range(0, 99) < badcrc_pct) ? 8'($urandom_range(1, 255)) : 8'h00;
    steps.push_back(row(MODE_START, q, rand_byte()));
    repeat (nw) steps.push_back(row(MODE_WAIT, 1'($urandom_range(0, 1)), rand_byte()));
    if (!late || $urandom_range(0, 1) != 0) begin
      steps.push_back(row(MODE_BYTE, 1'($urandom_range(0, 1)), rand_byte()));
      // a stray tick after the high byte is ignored
      if ($urandom_range(0, 99) < 5)
        steps.push_back(row(MODE_WAIT, 1'($urandom_range(0, 1)), rand_byte()));
      steps.push_back(row(MODE_BYTE, 1'($urandom_range(0, 1)), rand_byte()));
      s = row(MODE_BYTE, 1'($urandom_range(0, 1)), 8'h00);
      s.auto_crc = 1'b1;
      steps.push_back(s);
    end
    foreach (steps[i]) begin
      if (i < cut) offer(steps[i].mode, steps[i].qty,
                         steps[i].auto_crc ? (fr_crc ^ spoil) : steps[i].rx);
    end
  endtask

  task automatic traffic(input int target, input int timeout_pct, input int badcrc_pct);
    int base;
    base = frame_items;
    while (frame_items - base < target) begin
      if ($urandom_range(0, 99) < 20)
        offer(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), rand_byte());
      else
        send_frame(timeout_pct, badcrc_pct);
    end
  endtask

  // Wait until every reading is in and the pipeline has drained
  task automatic settle();
    in_ch.valid = 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic reconfigure(input logic [3:0] t_lim, input logic [3:0] h_lim);
    settle();
    write_reg(CFG_TEMP_LIMIT, t_lim);
    write_reg(CFG_HUMI_LIMIT, h_lim);
    cfg_ch.valid = 1'b0;
  endtask

  // Main sequence
  initial begin
    int extra;
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_START;
    in_ch.quantity = 1'b0;
    in_ch.rx_byte  = 8'h00;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_TEMP_LIMIT;
    cfg_ch.data    = 4'd0;
    row_pinned     = 1'b0;
    row_want       = '0;
    fr_phase       = PH_IDLE;
    fr_qty         = 1'b0;
    fr_waits       = 5'd0;
    fr_hi          = 8'h00;
    fr_lo          = 8'h00;
    fr_crc         = 8'h00;
    err_total      = 8'h00;
    lim_temp       = TEMP_LIMIT_AT_RESET;
    lim_humi       = HUMI_LIMIT_AT_RESET;
    rst_n          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table, run on the limits left by reset
    dir_rows.push_back(row(MODE_BYTE, 1'b0, 8'hFF));               // byte while idle
    dir_rows.push_back(row(MODE_WAIT, 1'b1, 8'h00));               // tick while idle
    dir_rows.push_back(row(MODE_SPARE, 1'b1, 8'hAA));              // unused mode
    dir_rows.push_back(row(MODE_START, 1'b0, 8'h00));
    dir_rows.push_back(row(MODE_BYTE, 1'b0, 8'h00));
    dir_rows.push_back(row(MODE_BYTE, 1'b0, 8'h00));
    dir_rows.push_back(checked_row(MODE_BYTE, 1'b0, 8'h00, 1'b0,   // lowest temperature
                                   1'b0, ST_OK, -4685, 16'h0000, 8'd0));
    dir_rows.push_back(row(MODE_START, 1'b1, 8'h00));
    dir_rows.push_back(row(MODE_BYTE, 1'b0, 8'hFF));
    dir_rows.push_back(row(MODE_WAIT, 1'b0, 8'h00));               // tick after high byte
    dir_rows.push_back(row(MODE_BYTE, 1'b0, 8'hFF));
    dir_rows.push_back(checked_row(MODE_BYTE, 1'b0, 8'h00, 1'b1,   // highest humidity
                                   1'b1, ST_OK, 11899, 16'hFFFC, 8'd0));
    dir_rows.push_back(row(MODE_START, 1'b1, 8'h00));
    dir_rows.push_back(row(MODE_BYTE, 1'b0, 8'h00));
    dir_rows.push_back(row(MODE_BYTE, 1'b0, 8'h00));
    dir_rows.push_back(checked_row(MODE_BYTE, 1'b0, 8'h01, 1'b0,   // CRC mismatch
                                   1'b1, ST_CRC, 0, 16'h0000, 8'd1));
    dir_rows.push_back(row(MODE_START, 1'b0, 8'h00));
    dir_rows.push_back(row(MODE_BYTE, 1'b0, 8'h12));
    dir_rows.push_back(row(MODE_START, 1'b1, 8'h00));              // restart drops frame
    repeat (5) dir_rows.push_back(row(MODE_WAIT, 1'b0, 8'h00));    // up to the limit
    dir_rows.push_back(checked_row(MODE_WAIT, 1'b0, 8'h00, 1'b0,   // one past: timeout
                                   1'b1, ST_TIMEOUT, 0, 16'h0000, 8'd2));
    foreach (dir_rows[i]) begin
      row_pinned = dir_rows[i].pinned;
      row_want   = dir_rows[i].want;
      offer(dir_rows[i].mode, dir_rows[i].qty,
            dir_rows[i].auto_crc ? fr_crc : dir_rows[i].rx);
    end
    row_pinned = 1'b0;

    // Random frames; the first phase also holds the sink off for a long while
    reconfigure(4'd15, 4'd15);
    hold_req = 1'b1;
    traffic(100, 15, 15);
    reconfigure(4'd0, 4'd15);
    traffic(80, 15, 15);

    send_idle_pct = 61;
    recv_idle_pct = 30;
    reconfigure(4'd15, 4'd0);
    traffic(80, 15, 15);

    // Error storm: drive the error counter into saturation and keep going
    reconfigure(4'd0, 4'd0);
    extra = 0;
    while (extra < 30) begin
      send_frame(75, 60);
      if (err_total == 8'hFF) extra++;
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    reconfigure(4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)));
    traffic(80, 15, 15);
    reconfigure(4'($urandom_range(1, 14)), 4'($urandom_range(1, 14)));
    traffic(60, 15, 15);

    settle();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/srfc_pkg.sv
src/srfc_in_if.sv
src/srfc_out_if.sv
src/srfc_cfg_if.sv
src/sensor_reading_frame_check.sv
tb/sensor_reading_frame_check_tb.sv
